FILE: rtl/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types and constants of the tiled light binning unit.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int MaxCells   = 4096;
  localparam int CellW      = $clog2(MaxCells);
  localparam int ListSlots  = 8;
  localparam int SlotW      = $clog2(ListSlots);
  localparam int CntW       = $clog2(ListSlots + 1);
  localparam int ListAddrW  = 1 + CellW + SlotW;
  localparam int DimW       = 7;
  localparam int TileW      = 6;
  localparam int DimMax     = 64;
  localparam int CoordW     = 16;
  localparam int QuotW      = CoordW - 1;
  localparam int SizeW      = 9;
  localparam int OffsW      = 17;
  localparam int CovW       = 13;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_EMIT   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REC_CLEAR_ACK = 2'd0,
    REC_APPEND    = 2'd1,
    REC_HEADER    = 2'd2,
    REC_ENTRY     = 2'd3
  } rec_kind_t;

  typedef enum logic [1:0] {
    REG_CELL_SIZE = 2'd0,
    REG_CELLS_X   = 2'd1,
    REG_CELLS_Y   = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_ACK,
    S_IDLE,
    S_DIV,
    S_WALK_RD,
    S_WALK_WR,
    S_APP_DONE,
    S_EMIT_RD,
    S_EMIT_HDR,
    S_ENT_RD,
    S_ENT_OUT
  } state_t;

endpackage

FILE: rtl/tiled_light_binning_unit.sv
// ----------------------------------------------------------------------------
// tiled_light_binning_unit
// Bins lights into per-tile point and spot lists and reads the tiles back.
// ----------------------------------------------------------------------------
// Results come out on a one-cycle strobe and cannot be held off, so the
// receiver must take every word when it appears. Busy stays high until the
// last word of an item is registered. After reset, and for every clear item,
// a clearing pass sweeps the 4096-entry count memory one entry per cycle;
// a clear item then sends a clear ack. An append runs the shared serial
// divider over the four box edges in turn, then a count read-modify-write
// (S_WALK_RD, S_WALK_WR) for each tile inside the clamped box, then sends
// the status word. An emit reads the count memory (S_EMIT_RD) and sends
// the header (S_EMIT_HDR), then for each stored index reads the list memory
// (S_ENT_RD) and sends the entry (S_ENT_OUT); memory reads are registered.
module tiled_light_binning_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic signed [19:0]       min_x,
  input  logic signed [19:0]       min_y,
  input  logic signed [19:0]       max_x,
  input  logic signed [19:0]       max_y,
  input  logic                     light_kind,
  input  logic [15:0]              light_number,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [8:0]               cfg_data,
  output logic                     strobe,
  output logic [1:0]               record_kind,
  output logic [11:0]              cell_number,
  output logic [16:0]              table_offset,
  output logic [3:0]               point_total,
  output logic [3:0]               spot_total,
  output logic [15:0]              entry_light,
  output logic [12:0]              cells_covered,
  output logic                     overflowed,
  output logic                     last
);

  tlb_pkg::state_t state, state_next;

  logic [tlb_pkg::SizeW-1:0] cell_size;
  logic [tlb_pkg::DimW-1:0]  cells_x, cells_y;

  logic [tlb_pkg::SizeW-1:0] cs_eff;
  logic [tlb_pkg::DimW-1:0]  cx_eff, cy_eff;
  logic [tlb_pkg::CellW:0]   n_use;

  // count memory: {spot, point} per tile
  logic [2*tlb_pkg::CntW-1:0] cnt_mem [tlb_pkg::MaxCells];
  logic [2*tlb_pkg::CntW-1:0] cnt_rdata, cnt_wdata;
  logic [tlb_pkg::CellW-1:0]  cnt_raddr, cnt_waddr;
  logic                       cnt_we;

  logic [15:0]                    list_mem [2**tlb_pkg::ListAddrW];
  logic [15:0]                    list_rdata;
  logic [tlb_pkg::ListAddrW-1:0]  list_raddr, list_waddr;
  logic                           list_we;

  logic [tlb_pkg::CellW-1:0]  clr_addr;
  logic                       clr_ack;
  logic [tlb_pkg::OffsW-1:0]  running_offset;
  logic [tlb_pkg::CellW:0]    readout_cell;
  logic                       overflow_flag;

  logic signed [tlb_pkg::CoordW-1:0] crd [4];
  logic                      kind;
  logic [15:0]               light;
  logic [1:0]                div_idx;
  logic [3:0]                div_cnt;
  logic [tlb_pkg::SizeW-1:0] rem;
  logic [tlb_pkg::QuotW-1:0] num;
  logic [tlb_pkg::SizeW:0]   rem_sh;
  logic                      rem_ge;
  logic [tlb_pkg::TileW-1:0] tile [4];
  logic [tlb_pkg::TileW-1:0] tile_hi, tile_res;
  logic [tlb_pkg::TileW-1:0] wx, wy;
  logic [tlb_pkg::CovW-1:0]  walk_prod;
  logic [tlb_pkg::CellW-1:0] walk_cell;
  logic [tlb_pkg::CntW-1:0]  walk_cnt;
  logic                      walk_full, walk_end;
  logic [tlb_pkg::CovW-1:0]  covered;

  logic [tlb_pkg::CntW-1:0]  p_tot, s_tot, hdr_p, hdr_s;
  logic                      hdr_empty;
  logic                      ent_kind;
  logic [tlb_pkg::SlotW-1:0] ent_j;
  logic                      ent_last, ent_switch;

  logic                      accept;
  logic                      rec_valid;
  tlb_pkg::rec_kind_t        rec_kind;
  logic                      rec_last;

  assign accept    = start && !busy;
  assign busy      = (state != tlb_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign cs_eff = (cell_size == '0) ? tlb_pkg::SizeW'(1) : cell_size;
  assign cx_eff = (cells_x == '0) ? tlb_pkg::DimW'(1) :
                  (cells_x > tlb_pkg::DimW'(tlb_pkg::DimMax)) ?
                  tlb_pkg::DimW'(tlb_pkg::DimMax) : cells_x;
  assign cy_eff = (cells_y == '0) ? tlb_pkg::DimW'(1) :
                  (cells_y > tlb_pkg::DimW'(tlb_pkg::DimMax)) ?
                  tlb_pkg::DimW'(tlb_pkg::DimMax) : cells_y;
  assign n_use  = (tlb_pkg::CellW+1)'(cx_eff) * (tlb_pkg::CellW+1)'(cy_eff);

  // serial restoring divider step
  assign rem_sh = {rem, num[tlb_pkg::QuotW-1]};
  assign rem_ge = (rem_sh >= {1'b0, cs_eff});
  assign tile_hi = div_idx[0] ? tlb_pkg::TileW'(cy_eff - 1'b1)
                              : tlb_pkg::TileW'(cx_eff - 1'b1);
  assign tile_res = crd[div_idx][tlb_pkg::CoordW-1] ? '0 :
                    (num > tlb_pkg::QuotW'(tile_hi)) ? tile_hi :
                    num[tlb_pkg::TileW-1:0];

  assign walk_prod = (tlb_pkg::CovW'(wy) * tlb_pkg::CovW'(cx_eff)) + tlb_pkg::CovW'(wx);
  assign walk_cell = walk_prod[tlb_pkg::CellW-1:0];
  assign walk_cnt  = kind ? cnt_rdata[2*tlb_pkg::CntW-1:tlb_pkg::CntW]
                          : cnt_rdata[tlb_pkg::CntW-1:0];
  assign walk_full = (walk_cnt >= tlb_pkg::CntW'(tlb_pkg::ListSlots));
  assign walk_end  = (wx == tile[2]) && (wy == tile[3]);

  assign hdr_p = cnt_rdata[tlb_pkg::CntW-1:0];
  assign hdr_s = cnt_rdata[2*tlb_pkg::CntW-1:tlb_pkg::CntW];
  // both lists can hold eight, so test each count rather than their sum
  assign hdr_empty = (hdr_p == '0) && (hdr_s == '0);

  assign ent_switch = !ent_kind && (tlb_pkg::CntW'(ent_j) + 1'b1 == p_tot);
  assign ent_last   = ent_kind ? (tlb_pkg::CntW'(ent_j) + 1'b1 == s_tot)
                               : (ent_switch && s_tot == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tlb_pkg::S_CLEAR: begin
        if (clr_addr == tlb_pkg::CellW'(tlb_pkg::MaxCells - 1)) begin
          state_next = clr_ack ? tlb_pkg::S_ACK : tlb_pkg::S_IDLE;
        end
      end
      tlb_pkg::S_ACK: state_next = tlb_pkg::S_IDLE;
      tlb_pkg::S_IDLE: begin
        if (accept) begin
          case (mode)
            tlb_pkg::MODE_CLEAR:  state_next = tlb_pkg::S_CLEAR;
            tlb_pkg::MODE_APPEND: state_next = tlb_pkg::S_DIV;
            tlb_pkg::MODE_EMIT:   state_next = tlb_pkg::S_EMIT_RD;
            default:              state_next = tlb_pkg::S_IDLE;
          endcase
        end
      end
      tlb_pkg::S_DIV: begin
        if (div_cnt == 4'd15 && div_idx == 2'd3) begin
          if (tile[0] > tile[2] || tile[1] > tile_res) begin
            state_next = tlb_pkg::S_APP_DONE;
          end else begin
            state_next = tlb_pkg::S_WALK_RD;
          end
        end
      end
      tlb_pkg::S_WALK_RD: state_next = tlb_pkg::S_WALK_WR;
      tlb_pkg::S_WALK_WR: state_next = walk_end ? tlb_pkg::S_APP_DONE : tlb_pkg::S_WALK_RD;
      tlb_pkg::S_APP_DONE: state_next = tlb_pkg::S_IDLE;
      tlb_pkg::S_EMIT_RD: state_next = tlb_pkg::S_EMIT_HDR;
      tlb_pkg::S_EMIT_HDR: begin
        state_next = hdr_empty ? tlb_pkg::S_IDLE : tlb_pkg::S_ENT_RD;
      end
      tlb_pkg::S_ENT_RD: state_next = tlb_pkg::S_ENT_OUT;
      tlb_pkg::S_ENT_OUT: state_next = ent_last ? tlb_pkg::S_IDLE : tlb_pkg::S_ENT_RD;
      default: state_next = tlb_pkg::S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    rec_valid  = 1'b0;
    rec_kind   = tlb_pkg::REC_CLEAR_ACK;
    rec_last   = 1'b1;
    cnt_we     = 1'b0;
    cnt_waddr  = walk_cell;
    cnt_wdata  = cnt_rdata;
    cnt_raddr  = walk_cell;
    list_we    = 1'b0;
    list_waddr = {kind, walk_cell, walk_cnt[tlb_pkg::SlotW-1:0]};
    list_raddr = {ent_kind, readout_cell[tlb_pkg::CellW-1:0], ent_j};
    unique case (state)
      tlb_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
      end
      tlb_pkg::S_ACK: rec_valid = 1'b1;
      tlb_pkg::S_WALK_WR: begin
        if (!walk_full) begin
          cnt_we  = 1'b1;
          list_we = 1'b1;
          if (kind) begin
            cnt_wdata[2*tlb_pkg::CntW-1:tlb_pkg::CntW] = walk_cnt + 1'b1;
          end else begin
            cnt_wdata[tlb_pkg::CntW-1:0] = walk_cnt + 1'b1;
          end
        end
      end
      tlb_pkg::S_APP_DONE: begin
        rec_valid = 1'b1;
        rec_kind  = tlb_pkg::REC_APPEND;
      end
      tlb_pkg::S_EMIT_RD: cnt_raddr = readout_cell[tlb_pkg::CellW-1:0];
      tlb_pkg::S_EMIT_HDR: begin
        rec_valid = 1'b1;
        rec_kind  = tlb_pkg::REC_HEADER;
        rec_last  = hdr_empty;
      end
      tlb_pkg::S_ENT_OUT: begin
        rec_valid = 1'b1;
        rec_kind  = tlb_pkg::REC_ENTRY;
        rec_last  = ent_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= light;
    end
    list_rdata <= list_mem[list_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= tlb_pkg::SizeW'(16);
      cells_x   <= tlb_pkg::DimW'(tlb_pkg::DimMax);
      cells_y   <= tlb_pkg::DimW'(tlb_pkg::DimMax);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlb_pkg::REG_CELL_SIZE: cell_size <= cfg_data;
        tlb_pkg::REG_CELLS_X:   cells_x   <= cfg_data[tlb_pkg::DimW-1:0];
        tlb_pkg::REG_CELLS_Y:   cells_y   <= cfg_data[tlb_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tlb_pkg::S_CLEAR;
      clr_addr       <= '0;
      clr_ack        <= 1'b0;
      running_offset <= '0;
      readout_cell   <= '0;
      overflow_flag  <= 1'b0;
      strobe         <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= rec_valid;
      unique case (state)
        tlb_pkg::S_CLEAR: clr_addr <= clr_addr + 1'b1;
        tlb_pkg::S_IDLE: begin
          if (accept) begin
            if (mode == tlb_pkg::MODE_CLEAR) begin
              clr_ack        <= 1'b1;
              running_offset <= '0;
              readout_cell   <= '0;
              overflow_flag  <= 1'b0;
            end else if (mode == tlb_pkg::MODE_EMIT && readout_cell >= n_use) begin
              readout_cell   <= '0;
              running_offset <= '0;
            end
          end
        end
        tlb_pkg::S_WALK_WR: begin
          if (walk_full) begin
            overflow_flag <= 1'b1;
          end
        end
        tlb_pkg::S_EMIT_HDR: begin
          if (hdr_empty) begin
            readout_cell <= readout_cell + 1'b1;
          end
        end
        tlb_pkg::S_ENT_OUT: begin
          if (ent_last) begin
            readout_cell   <= readout_cell + 1'b1;
            running_offset <= running_offset + tlb_pkg::OffsW'(p_tot)
                              + tlb_pkg::OffsW'(s_tot);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      tlb_pkg::S_IDLE: begin
        crd[0]  <= min_x[19:4];
        crd[1]  <= min_y[19:4];
        crd[2]  <= max_x[19:4];
        crd[3]  <= max_y[19:4];
        kind    <= light_kind;
        light   <= light_number;
        div_idx <= '0;
        div_cnt <= '0;
        rem     <= '0;
        num     <= min_x[18:4];
        covered <= '0;
      end
      tlb_pkg::S_DIV: begin
        if (div_cnt == 4'd15) begin
          tile[div_idx] <= tile_res;
          div_idx       <= div_idx + 1'b1;
          div_cnt       <= '0;
          rem           <= '0;
          num           <= crd[div_idx + 1'b1][tlb_pkg::QuotW-1:0];
          wx            <= tile[0];
          wy            <= (div_idx == 2'd3) ? tile[1] : wy;
        end else begin
          div_cnt <= div_cnt + 1'b1;
          rem     <= rem_ge ? tlb_pkg::SizeW'(rem_sh - {1'b0, cs_eff})
                            : rem_sh[tlb_pkg::SizeW-1:0];
          num     <= {num[tlb_pkg::QuotW-2:0], rem_ge};
        end
      end
      tlb_pkg::S_WALK_WR: begin
        if (!walk_full) begin
          covered <= covered + 1'b1;
        end
        if (wx == tile[2]) begin
          wx <= tile[0];
          wy <= wy + 1'b1;
        end else begin
          wx <= wx + 1'b1;
        end
      end
      tlb_pkg::S_EMIT_HDR: begin
        p_tot    <= hdr_p;
        s_tot    <= hdr_s;
        ent_kind <= (hdr_p == '0);
        ent_j    <= '0;
      end
      tlb_pkg::S_ENT_OUT: begin
        if (ent_switch) begin
          ent_kind <= 1'b1;
          ent_j    <= '0;
        end else begin
          ent_j <= ent_j + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    record_kind   <= rec_kind;
    last          <= rec_last;
    overflowed    <= overflow_flag;
    cell_number   <= '0;
    table_offset  <= '0;
    point_total   <= '0;
    spot_total    <= '0;
    entry_light   <= '0;
    cells_covered <= '0;
    unique case (rec_kind)
      tlb_pkg::REC_APPEND: cells_covered <= covered;
      tlb_pkg::REC_HEADER: begin
        cell_number  <= readout_cell[tlb_pkg::CellW-1:0];
        table_offset <= running_offset;
        point_total  <= hdr_p;
        spot_total   <= hdr_s;
      end
      tlb_pkg::REC_ENTRY: begin
        cell_number <= readout_cell[tlb_pkg::CellW-1:0];
        entry_light <= list_rdata;
      end
      default: ;
    endcase
  end

  a_ovf_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_flag) |-> $past(state == tlb_pkg::S_WALK_WR))
    else $error("overflow flag set outside a list update");

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> (state == tlb_pkg::S_ACK || state == tlb_pkg::S_APP_DONE ||
                   state == tlb_pkg::S_EMIT_HDR || state == tlb_pkg::S_ENT_OUT))
    else $error("result word from a non-output state");

  a_list_write_bound: assert property (@(posedge clk) disable iff (rst)
    list_we |-> (walk_cnt < tlb_pkg::CntW'(tlb_pkg::ListSlots)))
    else $error("list write past its last slot");

endmodule
